### hdl/nbf_pkg.sv
// ----------------------------------------------------------------------------
// NAL boundary finder package
// Shared widths, result types and NAL type helpers.
// ----------------------------------------------------------------------------
package nbf_pkg;

    // Internal offset width and the width that offsets are reported in.
    localparam int OFFSET_BITS = 32;
    localparam int OUT_BITS    = 32;
    localparam int TYPE_BITS   = 6;

    // Result queue depth; two entries must be free to take a byte.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Packed result stream widths.
    localparam int RES_DATA_BITS = OUT_BITS + TYPE_BITS + 1 + 1 + OUT_BITS + OUT_BITS;
    localparam int M_DATA_BITS   = ((RES_DATA_BITS + 7) / 8) * 8;

    // Header byte masks.
    localparam logic [7:0] START_CODE_BYTE = 8'h01;
    localparam logic [4:0] AVC_TYPE_MASK   = 5'h1F;

    // Result kinds.
    typedef enum logic
    {
        KIND_NAL     = 1'b0,
        KIND_PICTURE = 1'b1
    } kind_t;

    // Codec modes.
    typedef enum logic
    {
        MODE_AVC  = 1'b0,
        MODE_HEVC = 1'b1
    } codec_mode_t;

    // One result transaction.
    typedef struct packed
    {
        kind_t                 kind;
        logic [OUT_BITS-1:0]   nal_offset;
        logic [TYPE_BITS-1:0]  nal_type_code;
        logic                  is_slice;
        logic                  first_slice;
        logic [OUT_BITS-1:0]   picture_start;
        logic [OUT_BITS-1:0]   picture_end;
        logic                  last_result;
    } result_t;

    // Up to two results produced by one accepted byte.
    typedef struct packed
    {
        logic    valid_a;
        logic    valid_b;
        result_t res_a;
        result_t res_b;
    } result_pair_t;

    // AVC coded slice types are 1 to 5.
    function automatic logic avc_is_slice(input logic [TYPE_BITS-1:0] t);
        avc_is_slice = (t >= 6'd1) && (t <= 6'd5);
    endfunction

    // HEVC VCL slice types are 0 to 9 and 16 to 21.
    function automatic logic hevc_is_slice(input logic [TYPE_BITS-1:0] t);
        hevc_is_slice = (t <= 6'd9) || ((t >= 6'd16) && (t <= 6'd21));
    endfunction

endpackage

### hdl/nal_picture_boundary_finder.sv
// ----------------------------------------------------------------------------
// NAL picture boundary finder
// Scans an Annex B byte stream, classifies NAL units and reports picture
// boundaries.
//
//  Channel   Signals                          Contents
//  s_*       s_tvalid s_tready s_tdata s_tlast stream bytes in, tlast = end of stream
//  m_*       m_tvalid m_tready m_tdata m_tuser m_tlast results out, tuser = kind
//  cfg_*     cfg_we cfg_wdata                 codec mode register, 0 AVC, 1 HEVC
//
// One byte is taken per cycle while s_tready is high; its results enter the
// output queue at the same clock edge and appear on m_tvalid in the next cycle.
// Each byte gives up to two results, drained at one per cycle while m_tready is
// high from a four-entry queue; s_tready is high while two entries are free.
// Reset clears the parser and empties the queue; the codec mode resets to AVC.
// A stall on the result side fills the queue and then holds back the input.
// ----------------------------------------------------------------------------
module nal_picture_boundary_finder
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    // Byte stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] stream_byte
    input  logic                              s_tlast,
    // Results out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] nal_offset, [37:32] nal_type_code, [38] is_slice, [39] first_slice,
    // [71:40] picture_start, [103:72] picture_end
    output logic [nbf_pkg::M_DATA_BITS-1:0]   m_tdata,
    output logic                              m_tuser,   // [0] kind
    output logic                              m_tlast
);

    nbf_pkg::result_pair_t pair;
    nbf_pkg::result_t      res;
    logic                  take;
    logic                  room_two;

    // Input transaction
    assign take     = s_tvalid && s_tready;
    assign s_tready = room_two;

    nbf_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_take   (take),
        .in_byte   (s_tdata),
        .in_eos    (s_tlast),
        .out_pair  (pair)
    );

    nbf_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_pair   (pair),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Result packing
    assign m_tdata = nbf_pkg::M_DATA_BITS'({res.picture_end, res.picture_start,
                                            res.first_slice, res.is_slice,
                                            res.nal_type_code, res.nal_offset});
    assign m_tuser = res.kind;
    assign m_tlast = res.last_result;

endmodule

### hdl/nbf_parser.sv
// ----------------------------------------------------------------------------
// NAL boundary finder parser
// Start code search, NAL classification and picture bookkeeping, one byte per
// accepted transaction, giving up to two results.
// ----------------------------------------------------------------------------
module nbf_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_take,
    input  logic [7:0]            in_byte,
    input  logic                  in_eos,
    output nbf_pkg::result_pair_t out_pair
);

    typedef enum logic [2:0]
    {
        PH_SEARCH     = 3'd0,
        PH_HEADER     = 3'd1,
        PH_AVC_SLICE  = 3'd2,
        PH_HEVC_HDR2  = 3'd3,
        PH_HEVC_SLICE = 3'd4,
        PH_DONE       = 3'd5
    } phase_t;

    localparam int OB = nbf_pkg::OFFSET_BITS;
    localparam int RB = nbf_pkg::OUT_BITS;
    localparam int TB = nbf_pkg::TYPE_BITS;

    // State registers
    nbf_pkg::codec_mode_t mode_reg;
    phase_t               phase_reg, phase_next;
    logic [OB-1:0]        pos_reg, pos_next;
    logic [1:0]           zrun_reg, zrun_next;
    logic [OB-1:0]        nal_start_reg, nal_start_next;
    logic [TB-1:0]        nal_type_reg, nal_type_next;
    logic                 slices_reg, slices_next;
    logic [OB-1:0]        after_reg, after_next;
    logic                 after_ok_reg, after_ok_next;
    logic [OB-1:0]        pic_start_reg, pic_start_next;

    // Working values
    logic                 cls_valid, cls_slice, cls_first;
    logic [TB-1:0]        hdr_type;
    logic                 pic1_valid, pic2_valid;
    logic [OB-1:0]        pic1_start, pic1_end, pic2_start, pic2_end;
    logic [OB-1:0]        sc_start;
    logic                 keep_nal;
    nbf_pkg::result_t     r_nal, r_pic1, r_pic2;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        zrun_next      = zrun_reg;
        nal_start_next = nal_start_reg;
        nal_type_next  = nal_type_reg;
        slices_next    = slices_reg;
        after_next     = after_reg;
        after_ok_next  = after_ok_reg;
        pic_start_next = pic_start_reg;
        cls_valid      = 1'b0;
        cls_slice      = 1'b0;
        cls_first      = 1'b0;
        hdr_type       = '0;
        pic1_valid     = 1'b0;
        pic1_start     = pic_start_reg;
        pic1_end       = '0;
        pic2_valid     = 1'b0;
        pic2_start     = '0;
        pic2_end       = '0;
        sc_start       = pos_reg - OB'(2);

        // Header and slice byte classification
        case (phase_reg)
            PH_HEADER:
            begin
                if (mode_reg == nbf_pkg::MODE_AVC)
                begin
                    hdr_type = TB'(in_byte[4:0] & nbf_pkg::AVC_TYPE_MASK);
                    if (nbf_pkg::avc_is_slice(hdr_type))
                        phase_next = PH_AVC_SLICE;
                    else
                        cls_valid = 1'b1;
                end
                else
                begin
                    hdr_type = in_byte[6:1];
                    if (nbf_pkg::hevc_is_slice(hdr_type))
                        phase_next = PH_HEVC_HDR2;
                    else
                        cls_valid = 1'b1;
                end
                nal_type_next = hdr_type;
            end
            PH_AVC_SLICE, PH_HEVC_SLICE:
            begin
                cls_valid = 1'b1;
                cls_slice = 1'b1;
                cls_first = in_byte[7];
            end
            PH_HEVC_HDR2:
            begin
                phase_next = PH_HEVC_SLICE;
            end
            default:
            begin
            end
        endcase

        // A finished slice may close the previous picture
        if (cls_valid)
        begin
            phase_next = PH_DONE;
            if (cls_slice)
            begin
                if (cls_first && slices_reg)
                begin
                    pic1_valid     = 1'b1;
                    pic1_end       = after_ok_reg ? after_reg : nal_start_reg;
                    pic_start_next = pic1_end;
                end
                slices_next   = 1'b1;
                after_ok_next = 1'b0;
            end
        end

        // Start code detection and zero run tracking
        if ((in_byte == nbf_pkg::START_CODE_BYTE) && (zrun_reg == 2'd2))
        begin
            if (phase_next == PH_SEARCH)
                pic_start_next = sc_start;
            if (slices_next && !after_ok_next)
            begin
                after_next    = sc_start;
                after_ok_next = 1'b1;
            end
            nal_start_next = sc_start;
            nal_type_next  = '0;
            phase_next     = PH_HEADER;
            zrun_next      = 2'd0;
        end
        else if (in_byte == 8'h00)
        begin
            zrun_next = (zrun_reg == 2'd2) ? 2'd2 : zrun_reg + 2'd1;
        end
        else
        begin
            zrun_next = 2'd0;
        end

        // End of stream closes the open picture and restarts the parser
        if (in_eos)
        begin
            if (slices_next)
            begin
                pic2_valid = 1'b1;
                pic2_start = pic_start_next;
                pic2_end   = after_ok_next ? after_next : (pos_reg + OB'(1));
            end
            phase_next     = PH_SEARCH;
            pos_next       = '0;
            zrun_next      = 2'd0;
            nal_start_next = '0;
            nal_type_next  = '0;
            slices_next    = 1'b0;
            after_next     = '0;
            after_ok_next  = 1'b0;
            pic_start_next = '0;
        end
        else
        begin
            pos_next = pos_reg + OB'(1);
        end
    end

    // Candidate results; the NAL type is the one held before this byte's
    // start code or end of stream clears it.
    always_comb
    begin
        r_nal               = '0;
        r_nal.kind          = nbf_pkg::KIND_NAL;
        r_nal.nal_offset    = RB'(nal_start_reg);
        r_nal.nal_type_code = (phase_reg == PH_HEADER) ? hdr_type : nal_type_reg;
        r_nal.is_slice      = cls_slice;
        r_nal.first_slice   = cls_slice & cls_first;

        r_pic1               = '0;
        r_pic1.kind          = nbf_pkg::KIND_PICTURE;
        r_pic1.picture_start = RB'(pic1_start);
        r_pic1.picture_end   = RB'(pic1_end);

        r_pic2               = '0;
        r_pic2.kind          = nbf_pkg::KIND_PICTURE;
        r_pic2.picture_start = RB'(pic2_start);
        r_pic2.picture_end   = RB'(pic2_end);
    end

    // Compact to at most two results; with three, the NAL result is dropped
    always_comb
    begin
        keep_nal         = cls_valid && !(pic1_valid && pic2_valid);
        out_pair         = '0;
        out_pair.valid_a = in_take && (keep_nal || pic1_valid || pic2_valid);
        out_pair.valid_b = in_take && ((keep_nal && (pic1_valid || pic2_valid))
                                       || (pic1_valid && pic2_valid));
        out_pair.res_a   = keep_nal ? r_nal : (pic1_valid ? r_pic1 : r_pic2);
        out_pair.res_b   = (keep_nal && pic1_valid) ? r_pic1 : r_pic2;
        out_pair.res_a.last_result = !out_pair.valid_b;
        out_pair.res_b.last_result = 1'b1;
    end

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= nbf_pkg::MODE_AVC;
            phase_reg     <= PH_SEARCH;
            pos_reg       <= '0;
            zrun_reg      <= 2'd0;
            nal_start_reg <= '0;
            nal_type_reg  <= '0;
            slices_reg    <= 1'b0;
            after_reg     <= '0;
            after_ok_reg  <= 1'b0;
            pic_start_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= nbf_pkg::codec_mode_t'(cfg_wdata);
            if (in_take)
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                zrun_reg      <= zrun_next;
                nal_start_reg <= nal_start_next;
                nal_type_reg  <= nal_type_next;
                slices_reg    <= slices_next;
                after_reg     <= after_next;
                after_ok_reg  <= after_ok_next;
                pic_start_reg <= pic_start_next;
            end
        end
    end

endmodule

### hdl/nbf_out_queue.sv
// ----------------------------------------------------------------------------
// NAL boundary finder result queue
// Small register queue taking up to two results a cycle and giving one while out_ready is high.
// ----------------------------------------------------------------------------
module nbf_out_queue
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  nbf_pkg::result_pair_t      in_pair,
    output logic                       room_two,
    output logic                       out_valid,
    input  logic                       out_ready,
    output nbf_pkg::result_t           out_res
);

    localparam int D  = nbf_pkg::QUEUE_DEPTH;
    localparam int PB = nbf_pkg::QPTR_BITS;
    localparam int CB = nbf_pkg::QCNT_BITS;

    nbf_pkg::result_t entry_reg [D];
    logic [PB-1:0]    wr_reg, rd_reg;
    logic [CB-1:0]    count_reg, count_next;
    logic             pop;
    logic [1:0]       n_push;

    // Status towards both sides
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_reg];
    assign room_two  = (count_reg <= CB'(D - 2));
    assign pop       = out_valid && out_ready;
    assign n_push    = {1'b0, in_pair.valid_a} + {1'b0, in_pair.valid_b};

    always_comb
    begin
        count_next = count_reg + CB'(n_push) - CB'(pop);
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (in_pair.valid_a)
            entry_reg[wr_reg] <= in_pair.res_a;
        if (in_pair.valid_b)
            entry_reg[wr_reg + PB'(1)] <= in_pair.res_b;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + PB'(n_push);
            rd_reg    <= rd_reg + PB'(pop);
            count_reg <= count_next;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CB'(D))
        else $error("result queue overfilled");

    // A second result never arrives without a first.
    assert property (@(posedge clk) disable iff (!rst_n) in_pair.valid_b |-> in_pair.valid_a)
        else $error("second result without first");

    // Results are only written when two entries are free.
    assert property (@(posedge clk) disable iff (!rst_n) in_pair.valid_a |-> room_two)
        else $error("result written without room");

    // The count follows the pushes and pops of the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     $past(rst_n) |-> count_reg == $past(count_next))
        else $error("fill count out of step");

endmodule
